// ===== rtl/gtl_pkg.sv =====
package gtl_pkg;

   // Default capacity of one layout run.
   localparam int MAX_TILES_DEF = 64;

   // Field widths fixed by the interface.
   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 6;
   localparam int COORD_W  = 16;
   localparam int BORDER_W = 8;

   // The divider always works on a 16 bit dividend.
   localparam int DVD_W = COORD_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_PX   = 3'd4;

   localparam logic [COORD_W-1:0]  RST_ORIGIN_X    = 16'd0;
   localparam logic [COORD_W-1:0]  RST_ORIGIN_Y    = 16'd0;
   localparam logic [COORD_W-1:0]  RST_AREA_WIDTH  = 16'd1920;
   localparam logic [COORD_W-1:0]  RST_AREA_HEIGHT = 16'd1080;
   localparam logic [BORDER_W-1:0] RST_BORDER_PX   = 8'd1;

   // Operand selection for the shared divider.
   localparam logic [1:0] OP_COLS     = 2'd0;  // n / cols
   localparam logic [1:0] OP_WIDTH    = 2'd1;  // area_width / cols
   localparam logic [1:0] OP_H_TALL   = 2'd2;  // area_height / (q + 1)
   localparam logic [1:0] OP_H_SHORT  = 2'd3;  // area_height / q

   // Counter width able to hold the tile count and one more.
   function automatic int cnt_width(input int max_tiles);
      return $clog2(max_tiles + 1) + 1;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       start;
      logic       cols_inc;
      logic       div_start;
      logic       div_capture;
      logic [1:0] div_op;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic square_short;
      logic div_done;
      logic out_free;
      logic last;
   } status_type;

endpackage

// ===== rtl/grid_tile_layout.sv =====
// Grid tile layout: one request yields tile_count rectangles, column by column;
// the count is capped at MAX_TILES. A taken request first runs the column search, which
// raises the column count until its square reaches the tile count, then the four divisions
// on the shared 16 step divider. Then one rectangle leaves per cycle unless stalled.
// The next request is taken once the last rectangle has entered the output register.
// Reset is synchronous: it clears the controller and output valid and restores defaults.
module grid_tile_layout #(
   parameter int MAX_TILES = gtl_pkg::MAX_TILES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gtl_pkg::COUNT_W-1:0]    req_tile_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gtl_pkg::INDEX_W-1:0]    rsp_tile_index,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_x,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_y,
   output logic [gtl_pkg::COORD_W-1:0]    rsp_tile_w,
   output logic [gtl_pkg::COORD_W-1:0]    rsp_tile_h,
   output logic                           rsp_last_tile,
   input  logic                           csr_write,
   input  logic [gtl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gtl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gtl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   gtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Registers, divider, tile walk and output stage.
   gtl_datapath #(
      .MAX_TILES (MAX_TILES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_tile_count (req_tile_count),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_tile_index (rsp_tile_index),
      .rsp_tile_x     (rsp_tile_x),
      .rsp_tile_y     (rsp_tile_y),
      .rsp_tile_w     (rsp_tile_w),
      .rsp_tile_h     (rsp_tile_h),
      .rsp_last_tile  (rsp_last_tile)
   );

endmodule

// ===== rtl/gtl_div.sv =====
module gtl_div #(
   parameter int DVS_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gtl_pkg::DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]          divisor,
   output logic [gtl_pkg::DVD_W-1:0] quotient,
   output logic [DVS_W-1:0]          remainder,
   output logic                      done
);
   import gtl_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], fits};
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/gtl_datapath.sv =====
module gtl_datapath #(
   parameter int MAX_TILES = gtl_pkg::MAX_TILES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gtl_pkg::cmd_type             cmd,
   output gtl_pkg::status_type          status,
   input  logic [gtl_pkg::COUNT_W-1:0]  req_tile_count,
   input  logic                         csr_write,
   input  logic [gtl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gtl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic [gtl_pkg::INDEX_W-1:0]  rsp_tile_index,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_x,
   output logic signed [gtl_pkg::COORD_W-1:0] rsp_tile_y,
   output logic [gtl_pkg::COORD_W-1:0]  rsp_tile_w,
   output logic [gtl_pkg::COORD_W-1:0]  rsp_tile_h,
   output logic                         rsp_last_tile
);
   import gtl_pkg::*;

   localparam int CNT_W = cnt_width(MAX_TILES);
   localparam logic [8:0] MAX_9 = 9'(MAX_TILES);

   // Configuration registers.
   logic [COORD_W-1:0]  origin_x_ff, origin_x_in;
   logic [COORD_W-1:0]  origin_y_ff, origin_y_in;
   logic [COORD_W-1:0]  area_w_ff, area_w_in;
   logic [COORD_W-1:0]  area_h_ff, area_h_in;
   logic [BORDER_W-1:0] border_ff, border_in;

   // Per-run values.
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   cols_ff, cols_in;
   logic [CNT_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]   r_ff, r_in;
   logic [COORD_W-1:0] xq_ff, xq_in;
   logic [CNT_W-1:0]   xr_ff, xr_in;
   logic [COORD_W-1:0] tq_ff, tq_in;
   logic [CNT_W-1:0]   tr_ff, tr_in;
   logic [COORD_W-1:0] sq_ff, sq_in;
   logic [CNT_W-1:0]   sr_ff, sr_in;

   // Walk position and running offsets.
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [COORD_W-1:0] xaq_ff, xaq_in;
   logic [CNT_W-1:0]   xar_ff, xar_in;
   logic [COORD_W-1:0] yaq_ff, yaq_in;
   logic [CNT_W-1:0]   yar_ff, yar_in;

   // Output stage.
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic [COORD_W-1:0] out_w_ff, out_w_in;
   logic [COORD_W-1:0] out_h_ff, out_h_in;
   logic               out_last_ff, out_last_in;

   logic [8:0]         count_9;
   logic [CNT_W-1:0]   n_sat;
   logic [2*CNT_W-1:0] square;
   logic [DVD_W-1:0]   div_dividend;
   logic [CNT_W-1:0]   div_divisor;
   logic [DVD_W-1:0]   div_quotient;
   logic [CNT_W-1:0]   div_remainder;
   logic               div_done;

   logic               tall_col;
   logic [CNT_W-1:0]   rows_cur;
   logic [COORD_W-1:0] hq_cur;
   logic [CNT_W-1:0]   hr_cur;
   logic [CNT_W:0]     yr_sum;
   logic               y_carry;
   logic [CNT_W:0]     xr_sum;
   logic               x_carry;
   logic               col_end;
   logic               last;
   logic [COORD_W-1:0] cut;
   logic [COORD_W-1:0] border_ext;

   // Saturate the requested count at the capacity.
   always_comb begin
      count_9 = {2'b00, req_tile_count};
      n_sat   = CNT_W'((count_9 > MAX_9) ? MAX_9 : count_9);
   end

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      area_w_in   = area_w_ff;
      area_h_in   = area_h_ff;
      border_in   = border_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X:    origin_x_in = csr_wdata;
            CSR_ORIGIN_Y:    origin_y_in = csr_wdata;
            CSR_AREA_WIDTH:  area_w_in   = csr_wdata;
            CSR_AREA_HEIGHT: area_h_in   = csr_wdata;
            CSR_BORDER_PX:   border_in   = csr_wdata[BORDER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= RST_ORIGIN_X;
         origin_y_ff <= RST_ORIGIN_Y;
         area_w_ff   <= RST_AREA_WIDTH;
         area_h_ff   <= RST_AREA_HEIGHT;
         border_ff   <= RST_BORDER_PX;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         area_w_ff   <= area_w_in;
         area_h_ff   <= area_h_in;
         border_ff   <= border_in;
      end
   end

   // Column search compares the square of the candidate with the count.
   assign square = cols_ff * cols_ff;

   // Divider operand selection.
   always_comb begin
      div_dividend = area_h_ff;
      div_divisor  = q_ff;
      case (cmd.div_op)
         OP_COLS: begin
            div_dividend = DVD_W'(n_ff);
            div_divisor  = cols_ff;
         end
         OP_WIDTH: begin
            div_dividend = area_w_ff;
            div_divisor  = cols_ff;
         end
         OP_H_TALL: begin
            div_dividend = area_h_ff;
            div_divisor  = q_ff + 1'b1;
         end
         default: begin
            div_dividend = area_h_ff;
            div_divisor  = q_ff;
         end
      endcase
   end

   gtl_div #(
      .DVS_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // Geometry of the tile at the current walk position.
   always_comb begin
      tall_col   = col_ff < r_ff;
      rows_cur   = tall_col ? (q_ff + 1'b1) : q_ff;
      hq_cur     = tall_col ? tq_ff : sq_ff;
      hr_cur     = tall_col ? tr_ff : sr_ff;
      yr_sum     = {1'b0, yar_ff} + {1'b0, hr_cur};
      y_carry    = yr_sum >= {1'b0, rows_cur};
      xr_sum     = {1'b0, xar_ff} + {1'b0, xr_ff};
      x_carry    = xr_sum >= {1'b0, cols_ff};
      col_end    = ({1'b0, row_ff} + 1'b1) == {1'b0, rows_cur};
      last       = ({1'b0, k_ff} + 1'b1) == {1'b0, n_ff};
      cut        = COORD_W'({border_ff, 1'b0});
      border_ext = COORD_W'(border_ff);
   end

   // Run set-up, divider results and the walk over columns and rows.
   always_comb begin
      n_in   = n_ff;
      cols_in = cols_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      xq_in  = xq_ff;
      xr_in  = xr_ff;
      tq_in  = tq_ff;
      tr_in  = tr_ff;
      sq_in  = sq_ff;
      sr_in  = sr_ff;
      col_in = col_ff;
      row_in = row_ff;
      k_in   = k_ff;
      xaq_in = xaq_ff;
      xar_in = xar_ff;
      yaq_in = yaq_ff;
      yar_in = yar_ff;
      if (cmd.start) begin
         n_in    = n_sat;
         cols_in = CNT_W'(1);
      end
      if (cmd.cols_inc) begin
         cols_in = cols_ff + 1'b1;
      end
      if (cmd.div_capture) begin
         case (cmd.div_op)
            OP_COLS: begin
               q_in = CNT_W'(div_quotient);
               r_in = div_remainder;
            end
            OP_WIDTH: begin
               xq_in = div_quotient;
               xr_in = div_remainder;
            end
            OP_H_TALL: begin
               tq_in = div_quotient;
               tr_in = div_remainder;
            end
            default: begin
               sq_in  = div_quotient;
               sr_in  = div_remainder;
               col_in = '0;
               row_in = '0;
               k_in   = '0;
               xaq_in = '0;
               xar_in = '0;
               yaq_in = '0;
               yar_in = '0;
            end
         endcase
      end
      if (cmd.emit) begin
         k_in = k_ff + 1'b1;
         if (col_end) begin
            col_in = col_ff + 1'b1;
            row_in = '0;
            yaq_in = '0;
            yar_in = '0;
            xaq_in = xaq_ff + xq_ff + COORD_W'(x_carry);
            xar_in = x_carry ? CNT_W'(xr_sum - {1'b0, cols_ff}) : xr_sum[CNT_W-1:0];
         end else begin
            row_in = row_ff + 1'b1;
            yaq_in = yaq_ff + hq_cur + COORD_W'(y_carry);
            yar_in = y_carry ? CNT_W'(yr_sum - {1'b0, rows_cur}) : yr_sum[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      cols_ff <= cols_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      xq_ff  <= xq_in;
      xr_ff  <= xr_in;
      tq_ff  <= tq_in;
      tr_ff  <= tr_in;
      sq_ff  <= sq_in;
      sr_ff  <= sr_in;
      col_ff <= col_in;
      row_ff <= row_in;
      k_ff   <= k_in;
      xaq_ff <= xaq_in;
      xar_ff <= xar_in;
      yaq_ff <= yaq_in;
      yar_ff <= yar_in;
   end

   // Output register: loaded on emit, emptied by a transfer.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_index_in = INDEX_W'(k_ff);
         out_x_in     = origin_x_ff + border_ext + xaq_ff;
         out_y_in     = origin_y_ff + border_ext + yaq_ff;
         out_w_in     = (xq_ff > cut) ? (xq_ff - cut) : '0;
         out_h_in     = (hq_cur > cut) ? (hq_cur - cut) : '0;
         out_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_index_ff <= out_index_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_w_ff     <= out_w_in;
      out_h_ff     <= out_h_in;
      out_last_ff  <= out_last_in;
   end

   // Status back to the controller.
   always_comb begin
      status.count_zero   = req_tile_count == '0;
      status.square_short = square < (2*CNT_W)'(n_ff);
      status.div_done     = div_done;
      status.out_free     = !out_valid_ff || !rsp_stall;
      status.last         = last;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_tile_index = out_index_ff;
   assign rsp_tile_x     = out_x_ff;
   assign rsp_tile_y     = out_y_ff;
   assign rsp_tile_w     = out_w_ff;
   assign rsp_tile_h     = out_h_ff;
   assign rsp_last_tile  = out_last_ff;

endmodule

// ===== rtl/gtl_ctrl.sv =====
module gtl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output gtl_pkg::cmd_type    cmd,
   input  gtl_pkg::status_type status
);
   import gtl_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_DIV_Q   = 3'd2;
   localparam logic [2:0] ST_DIV_X   = 3'd3;
   localparam logic [2:0] ST_DIV_HT  = 3'd4;
   localparam logic [2:0] ST_DIV_HS  = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       launched_ff, launched_in;
   logic       in_div;
   logic [2:0] div_next;
   logic [1:0] div_op;

   // Divider states share one launch-and-wait pattern.
   always_comb begin
      in_div   = 1'b0;
      div_next = ST_IDLE;
      div_op   = OP_COLS;
      unique case (state_ff)
         ST_DIV_Q: begin
            in_div = 1'b1;
            div_op = OP_COLS;
            div_next = ST_DIV_X;
         end
         ST_DIV_X: begin
            in_div = 1'b1;
            div_op = OP_WIDTH;
            div_next = ST_DIV_HT;
         end
         ST_DIV_HT: begin
            in_div = 1'b1;
            div_op = OP_H_TALL;
            div_next = ST_DIV_HS;
         end
         ST_DIV_HS: begin
            in_div = 1'b1;
            div_op = OP_H_SHORT;
            div_next = ST_EMIT;
         end
         default: ;
      endcase
   end

   // Sequencing of one layout run.
   always_comb begin
      state_in        = state_ff;
      launched_in     = launched_ff;
      cmd.start       = 1'b0;
      cmd.cols_inc    = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_capture = 1'b0;
      cmd.div_op      = div_op;
      cmd.emit        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (!status.count_zero) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (status.square_short) begin
               cmd.cols_inc = 1'b1;
            end else begin
               state_in = ST_DIV_Q;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            if (in_div) begin
               if (!launched_ff) begin
                  cmd.div_start = 1'b1;
                  launched_in   = 1'b1;
               end else if (status.div_done) begin
                  cmd.div_capture = 1'b1;
                  launched_in     = 1'b0;
                  state_in        = div_next;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// ===== rtl/gtl_checker.sv =====
module gtl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [gtl_pkg::COUNT_W-1:0]    req_tile_count,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [gtl_pkg::INDEX_W-1:0]    rsp_tile_index,
   input logic [gtl_pkg::COORD_W-1:0]    rsp_tile_x,
   input logic [gtl_pkg::COORD_W-1:0]    rsp_tile_y,
   input logic [gtl_pkg::COORD_W-1:0]    rsp_tile_w,
   input logic [gtl_pkg::COORD_W-1:0]    rsp_tile_h,
   input logic                           rsp_last_tile
);
   import gtl_pkg::*;

   logic [INDEX_W-1:0] expect_idx_ff, expect_idx_in;
   logic               rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Position expected in the next result transfer.
   always_comb begin
      expect_idx_in = expect_idx_ff;
      if (rsp_xfer) begin
         expect_idx_in = rsp_last_tile ? '0 : (expect_idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_idx_ff <= '0;
      end else begin
         expect_idx_ff <= expect_idx_in;
      end
   end

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tile_index) &&
         $stable(rsp_tile_x) && $stable(rsp_tile_y) && $stable(rsp_tile_w) &&
         $stable(rsp_tile_h) && $stable(rsp_last_tile))
      else $error("stalled result changed");

   // Results of a run are numbered from zero without gaps.
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> rsp_tile_index == expect_idx_ff)
      else $error("tile index out of order");

   // A run with tiles keeps the request side stalled while it computes.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_tile_count != '0 |=> req_stall)
      else $error("request side not stalled during a run");

endmodule

bind grid_tile_layout gtl_checker u_gtl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_tile_count (req_tile_count),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_tile_index (rsp_tile_index),
   .rsp_tile_x     (rsp_tile_x),
   .rsp_tile_y     (rsp_tile_y),
   .rsp_tile_w     (rsp_tile_w),
   .rsp_tile_h     (rsp_tile_h),
   .rsp_last_tile  (rsp_last_tile)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gtl_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int IDLE_PCT     = 38;

   // One tile rectangle as it leaves the block.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic               last;
   } tile_rect_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COUNT_W-1:0]    req_tile_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [INDEX_W-1:0]    rsp_tile_index;
   logic signed [COORD_W-1:0] rsp_tile_x;
   logic signed [COORD_W-1:0] rsp_tile_y;
   logic [COORD_W-1:0]    rsp_tile_w;
   logic [COORD_W-1:0]    rsp_tile_h;
   logic                  rsp_last_tile;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the layout registers.
   logic [COORD_W-1:0]  org_x  = RST_ORIGIN_X;
   logic [COORD_W-1:0]  org_y  = RST_ORIGIN_Y;
   logic [COORD_W-1:0]  span_w = RST_AREA_WIDTH;
   logic [COORD_W-1:0]  span_h = RST_AREA_HEIGHT;
   logic [BORDER_W-1:0] inset  = RST_BORDER_PX;

   tile_rect_type pending_tiles[$];
   bit  req_idle_en = 1'b1;
   bit  rsp_idle_en = 1'b1;
   int  errors = 0;
   int  cycle_count = 0;
   int  layouts_sent = 0;
   int  tiles_checked = 0;
   int  settings_used = 1;

   grid_tile_layout dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tile_count (req_tile_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_index (rsp_tile_index),
      .rsp_tile_x     (rsp_tile_x),
      .rsp_tile_y     (rsp_tile_y),
      .rsp_tile_w     (rsp_tile_w),
      .rsp_tile_h     (rsp_tile_h),
      .rsp_last_tile  (rsp_last_tile),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("tb: errors");
         $finish;
      end
   end

   // A span less twice the border, held at zero when the border eats it all.
   function automatic logic [COORD_W-1:0] inset_span(input int span, input int brd);
      int size;
      size = (span > 2 * brd) ? span - 2 * brd : 0;
      return size[COORD_W-1:0];
   endfunction

   // Works out every rectangle of one layout request and queues them in order.
   task automatic lay_out_grid(input logic [COUNT_W-1:0] count);
      int n, cols, q, r, rows, col, row, k, w, h, b, ox, oy, pos;
      tile_rect_type t;
      n = count;
      if (n > MAX_TILES_DEF) n = MAX_TILES_DEF;
      if (n == 0) return;
      cols = 1;
      while (cols * cols < n) cols++;
      q = n / cols;
      r = n % cols;
      w = span_w;
      h = span_h;
      b = inset;
      ox = $signed(org_x);
      oy = $signed(org_y);
      k = 0;
      for (col = 0; col < cols && k < n; col++) begin
         rows = (col < r) ? q + 1 : q;
         for (row = 0; row < rows && k < n; row++) begin
            t.index = k[INDEX_W-1:0];
            pos = ox + b + (w * col) / cols;
            t.x = pos[COORD_W-1:0];
            pos = oy + b + (h * row) / rows;
            t.y = pos[COORD_W-1:0];
            t.w = inset_span(w / cols, b);
            t.h = inset_span(h / rows, b);
            t.last = (k + 1 == n);
            pending_tiles.push_back(t);
            k++;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [COORD_W-1:0] expv,
                                input logic [COORD_W-1:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
         errors++;
      end
   endtask

   // Checks one rectangle transfer against the oldest prediction.
   task automatic check_tile();
      tile_rect_type t;
      if (pending_tiles.size() == 0) begin
         $display("%0t: tile %0d arrived with no layout pending, expected none actual %h",
                  $time, rsp_tile_index, rsp_tile_x);
         errors++;
         return;
      end
      t = pending_tiles.pop_front();
      tiles_checked++;
      compare_field("tile_index", COORD_W'(t.index), COORD_W'(rsp_tile_index));
      compare_field("tile_x", t.x, rsp_tile_x);
      compare_field("tile_y", t.y, rsp_tile_y);
      compare_field("tile_w", t.w, rsp_tile_w);
      compare_field("tile_h", t.h, rsp_tile_h);
      compare_field("last_tile", COORD_W'(t.last), COORD_W'(rsp_last_tile));
   endtask

   // Result side: check each transfer, then choose the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_tile();
      rsp_stall <= rsp_idle_en && ($urandom_range(99) < IDLE_PCT);
   end

   // Offers one layout request and queues its rectangles once it is taken.
   task automatic send_layout(input logic [COUNT_W-1:0] count);
      while (req_idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tile_count <= count;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      lay_out_grid(count);
      layouts_sent++;
   endtask

   // Waits until every rectangle is back and the block has had time to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ORIGIN_X:    org_x  = data;
         CSR_ORIGIN_Y:    org_y  = data;
         CSR_AREA_WIDTH:  span_w = data;
         CSR_AREA_HEIGHT: span_h = data;
         CSR_BORDER_PX:   inset  = data[BORDER_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Writes a full register setting, plus noise on the unused indexes.
   task automatic apply_config(input logic [CSR_DATA_W-1:0] ox, input logic [CSR_DATA_W-1:0] oy,
                               input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] b);
      int i;
      wait_idle();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_AREA_WIDTH, w);
      write_csr(CSR_AREA_HEIGHT, h);
      write_csr(CSR_BORDER_PX, b);
      for (i = CSR_BORDER_PX + 1; i < 2 ** CSR_IDX_W; i++)
         write_csr(i[CSR_IDX_W-1:0], CSR_DATA_W'($urandom));
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_origin();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_span();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3, 4: return CSR_DATA_W'($urandom_range(1000));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // The upper byte is random: only the low byte reaches the border register.
   function automatic logic [CSR_DATA_W-1:0] pick_border();
      int sel;
      logic [7:0] upper;
      sel = $urandom_range(9);
      upper = 8'($urandom_range(255));
      case (sel)
         0: return {upper, 8'h00};
         1: return {upper, 8'hFF};
         2, 3, 4, 5: return {upper, 8'($urandom_range(20))};
         default: return {upper, 8'($urandom_range(255))};
      endcase
   endfunction

   // Mostly well-formed counts, some empty requests and some over capacity.
   function automatic logic [COUNT_W-1:0] pick_count();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return '0;
      if (sel < 13) return COUNT_W'($urandom_range(127, MAX_TILES_DEF + 1));
      if (sel < 35) return COUNT_W'($urandom_range(9, 1));
      return COUNT_W'($urandom_range(MAX_TILES_DEF, 1));
   endfunction

   // Reset defaults: empty run, square and ragged grids, full and saturated counts.
   task automatic test_reset_defaults();
      send_layout(0);
      send_layout(1);
      send_layout(2);
      send_layout(3);
      send_layout(4);
      send_layout(5);
      send_layout(7);
      send_layout(9);
      send_layout(10);
      send_layout(16);
      send_layout(17);
      send_layout(63);
      send_layout(64);
      send_layout(65);
      send_layout(127);
   endtask

   // Extreme areas: coordinate wrap-round, empty areas and borders wider than the tile.
   task automatic test_extreme_areas();
      apply_config(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_layout(64);
      send_layout(3);
      apply_config(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
      send_layout(64);
      send_layout(1);
      apply_config(16'hFFFF, 16'h0001, 16'd300, 16'd200, 16'd100);
      send_layout(2);
      send_layout(5);
   endtask

   // Random settings, each followed by a batch of random requests.
   task automatic test_random_layouts();
      int phase, i;
      for (phase = 0; phase < 6; phase++) begin
         apply_config(pick_origin(), pick_origin(), pick_span(), pick_span(), pick_border());
         req_idle_en = (phase != 3);
         rsp_idle_en = (phase != 3);
         for (i = 0; i < 45; i++) send_layout(pick_count());
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_areas();
      test_random_layouts();
      wait_idle();
      $display("summary: %0d layout requests over %0d register settings, %0d tiles checked",
               layouts_sent, settings_used, tiles_checked);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("%0t: %0d mismatches", $time, errors);
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/gtl_pkg.sv
rtl/gtl_div.sv
rtl/gtl_datapath.sv
rtl/gtl_ctrl.sv
rtl/grid_tile_layout.sv
rtl/gtl_checker.sv
verif/tb.sv
